// File: sv/rwsm_pkg.sv
// ----------------------------------------------------------------------------
// rwsm_pkg
// shared types and constants of the reed wheel speed meter
// ----------------------------------------------------------------------------
package rwsm_pkg;

    localparam int AVG_DEPTH_DEF = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int TICK_W  = 8;
    localparam int DEB_W   = 16;
    localparam int CONST_W = 24;
    localparam int IDLE_W  = 20;
    localparam int CLK_W   = 32;
    localparam int SPEED_W = 16;

    localparam int DIV_W     = 24;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [TICK_W-1:0]  TICK_MS_RST    = 8'd10;
    localparam logic [DEB_W-1:0]   DEBOUNCE_RST   = 16'd10;
    localparam logic [CONST_W-1:0] SPEED_K_RST    = 24'd1096701;
    localparam logic [IDLE_W-1:0]  IDLE_RST       = 20'd5000;
    localparam logic [CLK_W-1:0]   CLOCK_WRAP_RST = 32'd1000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_MS     = 3'd0,
        CFG_DEBOUNCE_MS = 3'd1,
        CFG_SPEED_K     = 3'd2,
        CFG_IDLE_MS     = 3'd3,
        CFG_CLOCK_WRAP  = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        PH_RELEASED = 4'b0001,
        PH_PRESSED  = 4'b0010,
        PH_FALLING  = 4'b0100,
        PH_RISING   = 4'b1000
    } phase_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIFF  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_STORE = 7'b0010000,
        S_AVG   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

endpackage

// File: sv/reed_wheel_speed_meter.sv
// ----------------------------------------------------------------------------
// reed_wheel_speed_meter
// debounced reed pulse period speedometer with a ring average
// ----------------------------------------------------------------------------
// throughput: one request at a time; the next one is taken as soon as the
// result sits in the output register
// the arithmetic is done by one 24-step restoring divider, one quotient bit a cycle,
// run once for the average and once more for the speed on a pulse
// reset: rst_n clears the debouncer, clocks, slots and pointer at once
module reed_wheel_speed_meter
    import rwsm_pkg::*;
#(
    parameter int AVERAGE_DEPTH = AVG_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  reed_level,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SPEED_W-1:0]    avg_speed,
    output logic                  pulse_seen,
    output logic [SPEED_W-1:0]    last_speed,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PTR_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam int SUM_W = SPEED_W + $clog2(AVERAGE_DEPTH);

    logic [TICK_W-1:0]  tick_ms_reg;
    logic [DEB_W-1:0]   debounce_ms_reg;
    logic [CONST_W-1:0] speed_k_reg;
    logic [IDLE_W-1:0]  idle_ms_reg;
    logic [CLK_W-1:0]   clock_wrap_reg;

    state_t             state_reg;
    phase_t             phase_reg;
    logic [DEB_W-1:0]   elapsed_reg;
    logic [CLK_W-1:0]   clock_reg;
    logic [CLK_W-1:0]   last_pulse_reg;
    logic [CLK_W-1:0]   diff_reg;
    logic [SPEED_W-1:0] slot_reg [AVERAGE_DEPTH];
    logic [PTR_W-1:0]   ptr_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SPEED_W-1:0] held_speed_reg;
    logic               pulse_reg;
    logic               div_speed_reg;

    logic [CLK_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [CLK_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic               out_valid_reg;
    logic [SPEED_W-1:0] avg_out_reg;
    logic               pulse_out_reg;
    logic [SPEED_W-1:0] last_out_reg;

    logic               accept;
    logic               out_load;
    logic [DEB_W:0]     elapsed_sum;
    logic [DEB_W-1:0]   elapsed_grown;
    logic               settled;
    logic [CLK_W+1:0]   trial;
    logic               borrow;
    logic [SPEED_W-1:0] speed_sat;
    logic [SPEED_W-1:0] old_slot;
    logic [PTR_W-1:0]   ptr_next;

    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign out_valid  = out_valid_reg;
    assign avg_speed  = avg_out_reg;
    assign pulse_seen = pulse_out_reg;
    assign last_speed = last_out_reg;

    assign elapsed_sum   = {1'b0, elapsed_reg} + (DEB_W+1)'(tick_ms_reg);
    assign elapsed_grown = elapsed_sum[DEB_W] ? {DEB_W{1'b1}} : elapsed_sum[DEB_W-1:0];
    assign settled       = (elapsed_reg >= debounce_ms_reg);

    // one restoring step: shift in the next dividend bit, try the subtract
    assign trial  = {1'b0, rem_reg, quo_reg[DIV_W-1]} - {2'b00, dsr_reg};
    assign borrow = trial[CLK_W+1];

    assign speed_sat = (|quo_reg[DIV_W-1:SPEED_W]) ? {SPEED_W{1'b1}} : quo_reg[SPEED_W-1:0];
    assign old_slot  = slot_reg[ptr_reg];
    assign ptr_next  = (ptr_reg == PTR_W'(AVERAGE_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ms_reg     <= TICK_MS_RST;
            debounce_ms_reg <= DEBOUNCE_RST;
            speed_k_reg     <= SPEED_K_RST;
            idle_ms_reg     <= IDLE_RST;
            clock_wrap_reg  <= CLOCK_WRAP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_TICK_MS:     tick_ms_reg     <= cfg_data[TICK_W-1:0];
                CFG_DEBOUNCE_MS: debounce_ms_reg <= cfg_data[DEB_W-1:0];
                CFG_SPEED_K:     speed_k_reg     <= cfg_data[CONST_W-1:0];
                CFG_IDLE_MS:     idle_ms_reg     <= cfg_data[IDLE_W-1:0];
                CFG_CLOCK_WRAP:  clock_wrap_reg  <= cfg_data[CLK_W-1:0];
                default:         ;
            endcase
        end
    end

    // sequencer, debouncer and serial divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_RELEASED;
            elapsed_reg    <= '0;
            clock_reg      <= '0;
            last_pulse_reg <= '0;
            diff_reg       <= '0;
            for (int i = 0; i < AVERAGE_DEPTH; i++)
            begin
                slot_reg[i] <= '0;
            end
            ptr_reg        <= '0;
            sum_reg        <= '0;
            held_speed_reg <= '0;
            pulse_reg      <= 1'b0;
            div_speed_reg  <= 1'b0;
            rem_reg        <= '0;
            quo_reg        <= '0;
            dsr_reg        <= '0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        clock_reg <= clock_reg + CLK_W'(tick_ms_reg);
                        pulse_reg <= (phase_reg == PH_RISING) && settled && !reed_level;
                        unique case (phase_reg)
                            PH_RELEASED:
                            begin
                                if (reed_level)
                                begin
                                    phase_reg   <= PH_FALLING;
                                    elapsed_reg <= '0;
                                end
                            end
                            PH_FALLING:
                            begin
                                if (settled)
                                begin
                                    phase_reg <= reed_level ? PH_PRESSED : PH_RELEASED;
                                end
                                elapsed_reg <= elapsed_grown;
                            end
                            PH_PRESSED:
                            begin
                                if (!reed_level)
                                begin
                                    phase_reg   <= PH_RISING;
                                    elapsed_reg <= '0;
                                end
                            end
                            PH_RISING:
                            begin
                                if (settled)
                                begin
                                    phase_reg <= reed_level ? PH_PRESSED : PH_RELEASED;
                                end
                                elapsed_reg <= elapsed_grown;
                            end
                            default:
                            begin
                                phase_reg <= PH_RELEASED;
                            end
                        endcase
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    diff_reg  <= clock_reg - last_pulse_reg;
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (pulse_reg)
                    begin
                        rem_reg       <= '0;
                        quo_reg       <= DIV_W'(speed_k_reg);
                        dsr_reg       <= diff_reg;
                        div_cnt_reg   <= DIV_CNT_W'(DIV_W - 1);
                        div_speed_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                    else
                    begin
                        if (diff_reg > CLK_W'(idle_ms_reg))
                        begin
                            for (int i = 0; i < AVERAGE_DEPTH; i++)
                            begin
                                slot_reg[i] <= '0;
                            end
                            sum_reg <= '0;
                        end
                        state_reg <= S_AVG;
                    end
                end
                S_DIV:
                begin
                    rem_reg     <= borrow ? {rem_reg[CLK_W-2:0], quo_reg[DIV_W-1]}
                                          : trial[CLK_W-1:0];
                    quo_reg     <= {quo_reg[DIV_W-2:0], !borrow};
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == '0)
                    begin
                        state_reg <= div_speed_reg ? S_STORE : S_DONE;
                    end
                end
                S_STORE:
                begin
                    held_speed_reg    <= speed_sat;
                    slot_reg[ptr_reg] <= speed_sat;
                    sum_reg           <= sum_reg - SUM_W'(old_slot) + SUM_W'(speed_sat);
                    ptr_reg           <= ptr_next;
                    if (clock_reg >= clock_wrap_reg)
                    begin
                        clock_reg      <= '0;
                        last_pulse_reg <= '0;
                    end
                    else
                    begin
                        last_pulse_reg <= clock_reg;
                    end
                    state_reg <= S_AVG;
                end
                S_AVG:
                begin
                    rem_reg       <= '0;
                    quo_reg       <= DIV_W'(sum_reg);
                    dsr_reg       <= CLK_W'(AVERAGE_DEPTH);
                    div_cnt_reg   <= DIV_CNT_W'(DIV_W - 1);
                    div_speed_reg <= 1'b0;
                    state_reg     <= S_DIV;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            avg_out_reg   <= quo_reg[SPEED_W-1:0];
            pulse_out_reg <= pulse_reg;
            last_out_reg  <= held_speed_reg;
        end
    end

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_W'(AVERAGE_DEPTH - 1))
        else $error("slot pointer out of range");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_DIFF)
        else $error("accepted request did not start");

    a_store_on_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STORE |-> pulse_reg)
        else $error("slot written without a pulse");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done state");

endmodule
